>>> rtl/spa_pkg.sv
package spa_pkg;

   localparam int COEF_W            = 32;
   localparam int EXPO_W            = 10;
   localparam int CMD_W             = 2;
   localparam int STEP_W            = 3;
   localparam int MAX_TERMS_DEFAULT = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_MERGE       = 2'd2
   } cmd_type;

   // One stored polynomial term.
   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic        [EXPO_W-1:0] expo;
   } term_type;

   // Result term as it leaves the block.
   typedef struct packed {
      logic signed [COEF_W-1:0] sum_coefficient;
      logic        [EXPO_W-1:0] sum_exponent;
      logic                     last_term;
      logic                     saturated;
      logic                     terms_dropped;
      logic                     both_empty;
   } rsp_type;

   // Write side control of the term store.
   typedef struct packed {
      logic load_first;
      logic load_second;
      logic clear;
   } store_ctl_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_CHECK = 3'd1;
   localparam step_type STEP_WALK  = 3'd2;
   localparam step_type STEP_EMPTY = 3'd3;
   localparam step_type STEP_DONE  = 3'd4;

   typedef enum logic [1:0] {
      EMIT_NONE  = 2'd0,
      EMIT_WALK  = 2'd1,
      EMIT_EMPTY = 2'd2
   } emit_sel_type;

   typedef enum logic [2:0] {
      COND_ALWAYS    = 3'd0,
      COND_MERGE     = 3'd1,
      COND_EMPTY     = 3'd2,
      COND_EMIT      = 3'd3,
      COND_EMIT_LAST = 3'd4
   } cond_type;

   // One control word of the merge program.
   typedef struct packed {
      logic         ready;
      emit_sel_type emit;
      logic         clear;
      cond_type     cond;
      step_type     on_true;
      step_type     on_false;
   } ucode_type;

   // Status fed back from the datapath to the sequencer.
   typedef struct packed {
      logic merge_go;
      logic lists_empty;
      logic emit_fire;
      logic emit_last;
   } status_type;

   // The merge program. Each step names its successor for a true and a false condition.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      unique case (step)
         STEP_IDLE:  w = '{1'b1, EMIT_NONE,  1'b0, COND_MERGE,     STEP_CHECK, STEP_IDLE};
         STEP_CHECK: w = '{1'b0, EMIT_NONE,  1'b0, COND_EMPTY,     STEP_EMPTY, STEP_WALK};
         STEP_WALK:  w = '{1'b0, EMIT_WALK,  1'b0, COND_EMIT_LAST, STEP_DONE,  STEP_WALK};
         STEP_EMPTY: w = '{1'b0, EMIT_EMPTY, 1'b0, COND_EMIT,      STEP_DONE,  STEP_EMPTY};
         STEP_DONE:  w = '{1'b0, EMIT_NONE,  1'b1, COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
         default:    w = '{1'b0, EMIT_NONE,  1'b0, COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

>>> rtl/spa_if.sv
interface spa_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [spa_pkg::CMD_W-1:0]       cmd;
   logic signed [spa_pkg::COEF_W-1:0]      coefficient;
   logic        [spa_pkg::EXPO_W-1:0]      exponent;

   modport source (output valid, cmd, coefficient, exponent, input ready);
   modport sink   (input valid, cmd, coefficient, exponent, output ready);
endinterface

interface spa_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [spa_pkg::COEF_W-1:0]      sum_coefficient;
   logic        [spa_pkg::EXPO_W-1:0]      sum_exponent;
   logic                                   last_term;
   logic                                   saturated;
   logic                                   terms_dropped;
   logic                                   both_empty;

   modport source (output valid, sum_coefficient, sum_exponent, last_term, saturated,
                   terms_dropped, both_empty, input ready);
   modport sink   (input valid, sum_coefficient, sum_exponent, last_term, saturated,
                   terms_dropped, both_empty, output ready);
endinterface

>>> rtl/spa_term_store.sv
module spa_term_store #(
   parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT,
   parameter int CNT_W     = $clog2(MAX_TERMS + 1),
   parameter int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spa_pkg::store_ctl_type  ctl,
   input  spa_pkg::term_type       wr_term,
   input  logic [IDX_W-1:0]        rd_idx_first,
   input  logic [IDX_W-1:0]        rd_idx_second,
   output spa_pkg::term_type       rd_first,
   output spa_pkg::term_type       rd_second,
   output logic [CNT_W-1:0]        first_count,
   output logic [CNT_W-1:0]        second_count,
   output logic                    overflow_seen
);

   spa_pkg::term_type first_mem  [MAX_TERMS];
   spa_pkg::term_type second_mem [MAX_TERMS];

   spa_pkg::term_type rd_first_ff, rd_second_ff;
   logic [CNT_W-1:0]  first_count_ff, first_count_in;
   logic [CNT_W-1:0]  second_count_ff, second_count_in;
   logic              overflow_ff, overflow_in;
   logic              first_full, second_full;
   logic              first_wr, second_wr;

   assign first_full  = (first_count_ff == CNT_W'(MAX_TERMS));
   assign second_full = (second_count_ff == CNT_W'(MAX_TERMS));
   assign first_wr    = ctl.load_first && !first_full;
   assign second_wr   = ctl.load_second && !second_full;

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      if (ctl.clear) begin
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end else begin
         if (first_wr) first_count_in = first_count_ff + CNT_W'(1);
         if (second_wr) second_count_in = second_count_ff + CNT_W'(1);
         if ((ctl.load_first && first_full) || (ctl.load_second && second_full)) begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (first_wr) first_mem[first_count_ff[IDX_W-1:0]] <= wr_term;
      rd_first_ff <= first_mem[rd_idx_first];
   end

   always_ff @(posedge clock) begin
      if (second_wr) second_mem[second_count_ff[IDX_W-1:0]] <= wr_term;
      rd_second_ff <= second_mem[rd_idx_second];
   end

   assign rd_first      = rd_first_ff;
   assign rd_second     = rd_second_ff;
   assign first_count   = first_count_ff;
   assign second_count  = second_count_ff;
   assign overflow_seen = overflow_ff;

endmodule

>>> rtl/spa_sequencer.sv
module spa_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  spa_pkg::status_type   status,
   output spa_pkg::ucode_type    ctl
);

   spa_pkg::step_type  step_ff, step_in;
   spa_pkg::ucode_type word;
   logic               cond_true;

   assign word = spa_pkg::ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         spa_pkg::COND_ALWAYS:    cond_true = 1'b1;
         spa_pkg::COND_MERGE:     cond_true = status.merge_go;
         spa_pkg::COND_EMPTY:     cond_true = status.lists_empty;
         spa_pkg::COND_EMIT:      cond_true = status.emit_fire;
         spa_pkg::COND_EMIT_LAST: cond_true = status.emit_fire && status.emit_last;
         default:                 cond_true = 1'b0;
      endcase
      step_in = cond_true ? word.on_true : word.on_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= spa_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl = word;

endmodule

>>> rtl/sparse_polynomial_add.sv
// Channel   Direction  Payload                                                Handshake
// req_chan  in         cmd, coefficient, exponent                             valid/ready
// rsp_chan  out        sum_coefficient, sum_exponent, last_term, saturated,   valid/ready
//                      terms_dropped, both_empty
//
// Loads are accepted back to back. A merge runs through acceptance, an emptiness check,
// one result term per cycle while the response slot is free, and a closing step that
// clears the lists; one read port per list sets the term rate.
// Reset is synchronous and clears the counts, the drop flag and the sequencer; the term
// memories are not cleared, as only entries below the counts are ever used.
// While a response waits and rsp_chan.ready is low the walk holds on its current term; no
// new request is taken until the merge has finished.
module sparse_polynomial_add #(
   parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   spa_req_if.sink  req_chan,
   spa_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   spa_pkg::ucode_type     ctl;
   spa_pkg::status_type    status;
   spa_pkg::store_ctl_type store_ctl;
   spa_pkg::term_type      wr_term, term_a, term_b;
   spa_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]       first_count, second_count;
   logic [CNT_W-1:0]       i_ff, i_in, j_ff, j_in;
   logic                   overflow_seen;
   logic                   req_fire;
   logic                   a_valid, b_valid, exp_equal, take_a;
   logic                   adv_a, adv_b, walk_last;
   logic signed [spa_pkg::COEF_W:0]   sum_wide;
   logic signed [spa_pkg::COEF_W-1:0] sum_sat;
   logic                   sum_ovf;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   slot_free, emit_req, emit_fire;

   // A transfer on the request side is only possible while the sequencer sits idle.
   assign req_chan.ready = ctl.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign wr_term.coef = req_chan.coefficient;
   assign wr_term.expo = req_chan.exponent;

   assign store_ctl.load_first  = req_fire && (req_chan.cmd == spa_pkg::CMD_LOAD_FIRST);
   assign store_ctl.load_second = req_fire && (req_chan.cmd == spa_pkg::CMD_LOAD_SECOND);
   assign store_ctl.clear       = ctl.clear;

   spa_term_store #(
      .MAX_TERMS (MAX_TERMS),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .ctl           (store_ctl),
      .wr_term       (wr_term),
      .rd_idx_first  (i_in[IDX_W-1:0]),
      .rd_idx_second (j_in[IDX_W-1:0]),
      .rd_first      (term_a),
      .rd_second     (term_b),
      .first_count   (first_count),
      .second_count  (second_count),
      .overflow_seen (overflow_seen)
   );

   // Merge datapath. The read addresses follow the next walk indices, so the registered
   // read data always belongs to the current indices.
   assign a_valid   = (i_ff < first_count);
   assign b_valid   = (j_ff < second_count);
   assign exp_equal = a_valid && b_valid && (term_a.expo == term_b.expo);
   assign take_a    = !exp_equal && (!b_valid || (a_valid && (term_a.expo > term_b.expo)));
   assign adv_a     = exp_equal || take_a;
   assign adv_b     = exp_equal || !take_a;
   assign walk_last = ((i_ff + CNT_W'(adv_a)) >= first_count) &&
                      ((j_ff + CNT_W'(adv_b)) >= second_count);

   // Sum of two coefficients with one guard bit, clipped to the 32-bit range.
   assign sum_wide = {term_a.coef[spa_pkg::COEF_W-1], term_a.coef} +
                     {term_b.coef[spa_pkg::COEF_W-1], term_b.coef};
   assign sum_ovf  = sum_wide[spa_pkg::COEF_W] != sum_wide[spa_pkg::COEF_W-1];
   assign sum_sat  = sum_ovf ?
                     (sum_wide[spa_pkg::COEF_W] ? {1'b1, {(spa_pkg::COEF_W-1){1'b0}}}
                                                : {1'b0, {(spa_pkg::COEF_W-1){1'b1}}})
                     : sum_wide[spa_pkg::COEF_W-1:0];

   assign emit_req  = (ctl.emit != spa_pkg::EMIT_NONE);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit_fire = emit_req && slot_free;

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (ctl.clear) begin
         i_in = '0;
         j_in = '0;
      end else if (emit_fire && (ctl.emit == spa_pkg::EMIT_WALK)) begin
         i_in = i_ff + CNT_W'(adv_a);
         j_in = j_ff + CNT_W'(adv_b);
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (emit_fire) begin
         rsp_data_in.terms_dropped = overflow_seen;
         if (ctl.emit == spa_pkg::EMIT_EMPTY) begin
            rsp_data_in.sum_coefficient = '0;
            rsp_data_in.sum_exponent    = '0;
            rsp_data_in.last_term       = 1'b1;
            rsp_data_in.saturated       = 1'b0;
            rsp_data_in.both_empty      = 1'b1;
         end else begin
            rsp_data_in.sum_coefficient = exp_equal ? sum_sat :
                                          (take_a ? term_a.coef : term_b.coef);
            rsp_data_in.sum_exponent    = adv_a ? term_a.expo : term_b.expo;
            rsp_data_in.last_term       = walk_last;
            rsp_data_in.saturated       = exp_equal && sum_ovf;
            rsp_data_in.both_empty      = 1'b0;
         end
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign status.merge_go    = req_fire && (req_chan.cmd == spa_pkg::CMD_MERGE);
   assign status.lists_empty = (first_count == '0) && (second_count == '0);
   assign status.emit_fire   = emit_fire;
   assign status.emit_last   = walk_last;

   spa_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.sum_coefficient = rsp_data_ff.sum_coefficient;
   assign rsp_chan.sum_exponent    = rsp_data_ff.sum_exponent;
   assign rsp_chan.last_term       = rsp_data_ff.last_term;
   assign rsp_chan.saturated       = rsp_data_ff.saturated;
   assign rsp_chan.terms_dropped   = rsp_data_ff.terms_dropped;
   assign rsp_chan.both_empty      = rsp_data_ff.both_empty;

   // The walk step always has at least one list with terms left.
   a_walk_has_term: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit == spa_pkg::EMIT_WALK) |-> (a_valid || b_valid))
      else $error("walk step with both lists exhausted");

   // The walk indices never run past the list lengths.
   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      (i_ff <= first_count) && (j_ff <= second_count))
      else $error("walk index beyond list length");

   // The final term of a walk is followed by the clearing step.
   a_last_then_clear: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && (ctl.emit == spa_pkg::EMIT_WALK) && walk_last) |=> ctl.clear)
      else $error("lists not cleared after final term");

   // A clipped sum holds one of the two range limits.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.saturated) |->
      ((rsp_data_ff.sum_coefficient == {1'b1, {(spa_pkg::COEF_W-1){1'b0}}}) ||
       (rsp_data_ff.sum_coefficient == {1'b0, {(spa_pkg::COEF_W-1){1'b1}}})))
      else $error("saturated term without a limit value");

endmodule
